### hw/rtl/rxs_pkg.sv
`default_nettype none

package rxs_pkg;

  localparam int MEM_DEPTH_DEF = 1024;
  localparam int PC_WIDTH_DEF  = 16;
  localparam int NUM_REGS      = 8;
  localparam int OUT_Q_DEPTH   = 4;

  localparam logic [2:0] LINK_REG = 3'd7;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_LSF = 4'd2,
    OP_RSF = 4'd3,
    OP_AND = 4'd4,
    OP_OR  = 4'd5,
    OP_XOR = 4'd6,
    OP_LHI = 4'd7,
    OP_LD  = 4'd8,
    OP_ST  = 4'd9,
    OP_JLT = 4'd10,
    OP_JLE = 4'd11,
    OP_JEQ = 4'd12,
    OP_JNE = 4'd13,
    OP_JIN = 4'd14,
    OP_HLT = 4'd15
  } rxs_op_t;

  typedef struct packed {
    logic [3:0]         req_type;
    logic [2:0]         dest_reg;
    logic [2:0]         src0_reg;
    logic [2:0]         src1_reg;
    logic signed [15:0] immediate;
    logic [15:0]        current_pc;
  } rxs_in_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic               jump_taken;
    logic               halted;
    logic               reg_write;
    logic [2:0]         write_index;
    logic signed [31:0] write_value;
  } rxs_out_t;

  // what the execute stage hands to the write-back stage
  typedef struct packed {
    logic        wr;
    logic [2:0]  widx;
    logic [31:0] wval;
    logic        is_ld;
    logic        ld_oob;
    logic [15:0] next_pc;
    logic        taken;
    logic        halt;
  } rxs_wb_t;

endpackage

`default_nettype wire

### hw/rtl/rxs_ram.sv
`default_nettype none

module rxs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/rxs_out_fifo.sv
`default_nettype none

module rxs_out_fifo import rxs_pkg::*; #(
  parameter int DEPTH = OUT_Q_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  rxs_out_t                   push_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rxs_out_t                   out_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rxs_out_t        slot [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            pop;

  assign out_valid = (count_r != '0);
  assign out_data  = slot[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/risc_execute_stage.sv
// Execute stage for a small load/store machine: takes one decoded instruction a cycle while
// in_ready is high and gives one result item per instruction, in order. The read stage
// reads the two register-file copies (8 x 32, one per source operand, registered read), the
// execute stage runs the ALU or branch compare and issues the data-memory access (MEM_DEPTH
// x 32, registered read), and the write-back stage takes load data, writes the register
// file and queues the result. Write-back results and the register write that just landed
// are forwarded to a younger instruction, so dependent instructions and loads followed by
// their users still run one per cycle while in_ready is high. A four-item result queue
// sits in front of out_*; in_ready falls only when the queue plus the two items in flight
// fill it, so the sustained rate is one item per cycle while out_ready stays high. Register
// r0 reads zero and ignores writes; data memory holds no defined value until stored.
`default_nettype none

module risc_execute_stage import rxs_pkg::*; #(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF,
  parameter int PC_WIDTH  = PC_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rxs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rxs_out_t out_data
);

  localparam int DM_AW = $clog2(MEM_DEPTH);
  localparam int RF_AW = $clog2(NUM_REGS);
  localparam int QC_W  = $clog2(OUT_Q_DEPTH + 1);
  localparam int OCC_W = $clog2(OUT_Q_DEPTH + 3);
  localparam logic [15:0] PC_MASK =
    (PC_WIDTH >= 16) ? 16'hffff : 16'((32'd1 << PC_WIDTH) - 32'd1);

  logic             in_acc;
  logic [RF_AW-1:0] rd_addr_a;

  // register file
  logic             rf_we;
  logic [RF_AW-1:0] rf_waddr;
  logic [31:0]      rf_wdata;
  logic [31:0]      rf_rdata_a, rf_rdata_b;
  logic [NUM_REGS-1:0] rf_valid_r;

  // read stage
  logic             s1_valid_r;
  rxs_op_t          s1_op_r;
  logic [2:0]       s1_dst_r;
  logic [RF_AW-1:0] s1_addr_a_r, s1_addr_b_r;
  logic [15:0]      s1_imm_r;
  logic [15:0]      s1_pc_r;
  logic             s1_va_r, s1_vb_r;

  // execute
  logic [31:0]      opa, opb;
  logic             b_in_range;
  logic             jcond;
  rxs_wb_t          s2_nxt;

  // data memory
  logic             dm_we;
  logic [31:0]      dm_rdata;

  // write-back stage
  logic             s2_valid_r;
  rxs_wb_t          s2_r;
  logic [31:0]      s2_wval;
  logic             wb_valid_r;
  logic [RF_AW-1:0] wb_idx_r;
  logic [31:0]      wb_val_r;

  // result queue
  rxs_out_t         q_push_data;
  logic [QC_W-1:0]  q_count;
  logic [OCC_W-1:0] occ;

  assign in_acc    = in_valid && in_ready;
  assign rd_addr_a = (rxs_op_t'(in_data.req_type) == OP_LHI) ? in_data.dest_reg
                                                             : in_data.src0_reg;

  rxs_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rd_addr_a),
    .rdata (rf_rdata_a)
  );

  rxs_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (in_data.src1_reg),
    .rdata (rf_rdata_b)
  );

  // registers never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_valid_r <= '0;
    end else if (rf_we) begin
      rf_valid_r[rf_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r     <= rxs_op_t'(in_data.req_type);
      s1_dst_r    <= in_data.dest_reg;
      s1_addr_a_r <= rd_addr_a;
      s1_addr_b_r <= in_data.src1_reg;
      s1_imm_r    <= in_data.immediate;
      s1_pc_r     <= in_data.current_pc;
      s1_va_r     <= rf_valid_r[rd_addr_a];
      s1_vb_r     <= rf_valid_r[in_data.src1_reg];
    end
  end

  // newest write wins: the one in write-back, then the one that landed as the read issued
  function automatic logic [31:0] fwd(input logic [RF_AW-1:0] addr,
                                      input logic [31:0] ram_data,
                                      input logic ram_valid,
                                      input logic s2_hit_en,
                                      input logic [RF_AW-1:0] s2_idx,
                                      input logic [31:0] s2_val,
                                      input logic wb_en,
                                      input logic [RF_AW-1:0] wb_idx,
                                      input logic [31:0] wb_val);
    logic [31:0] v;
    if (s2_hit_en && s2_idx == addr) begin
      v = s2_val;
    end else if (wb_en && wb_idx == addr) begin
      v = wb_val;
    end else if (ram_valid) begin
      v = ram_data;
    end else begin
      v = '0;
    end
    return v;
  endfunction

  always_comb begin
    opa = fwd(s1_addr_a_r, rf_rdata_a, s1_va_r, rf_we, rf_waddr, s2_wval,
              wb_valid_r, wb_idx_r, wb_val_r);
    opb = fwd(s1_addr_b_r, rf_rdata_b, s1_vb_r, rf_we, rf_waddr, s2_wval,
              wb_valid_r, wb_idx_r, wb_val_r);
  end

  assign b_in_range = (opb < 32'(MEM_DEPTH));

  always_comb begin
    s2_nxt         = '0;
    s2_nxt.widx    = s1_dst_r;
    s2_nxt.next_pc = (s1_pc_r + 16'd1) & PC_MASK;
    s2_nxt.ld_oob  = !b_in_range;
    jcond          = 1'b0;
    unique case (s1_op_r)
      OP_ADD: begin
        s2_nxt.wr   = 1'b1;
        s2_nxt.wval = opa + opb;
      end
      OP_SUB: begin
        s2_nxt.wr   = 1'b1;
        s2_nxt.wval = opa - opb;
      end
      OP_LSF: begin
        s2_nxt.wr   = 1'b1;
        s2_nxt.wval = opa << opb[4:0];
      end
      OP_RSF: begin
        s2_nxt.wr   = 1'b1;
        s2_nxt.wval = 32'($signed(opa) >>> opb[4:0]);
      end
      OP_AND: begin
        s2_nxt.wr   = 1'b1;
        s2_nxt.wval = opa & opb;
      end
      OP_OR: begin
        s2_nxt.wr   = 1'b1;
        s2_nxt.wval = opa | opb;
      end
      OP_XOR: begin
        s2_nxt.wr   = 1'b1;
        s2_nxt.wval = opa ^ opb;
      end
      OP_LHI: begin
        // operand a was read from the destination register
        s2_nxt.wr   = 1'b1;
        s2_nxt.wval = {s1_imm_r, opa[15:0]};
      end
      OP_LD: begin
        s2_nxt.wr    = 1'b1;
        s2_nxt.is_ld = 1'b1;
      end
      OP_ST: begin
      end
      OP_JLT: jcond = ($signed(opa) < $signed(opb));
      OP_JLE: jcond = ($signed(opa) <= $signed(opb));
      OP_JEQ: jcond = (opa == opb);
      OP_JNE: jcond = (opa != opb);
      OP_JIN: begin
        // link is written before the target is read, so a jump through r7 stays put
        s2_nxt.taken   = 1'b1;
        s2_nxt.wr      = 1'b1;
        s2_nxt.widx    = LINK_REG;
        s2_nxt.wval    = {16'd0, s1_pc_r};
        s2_nxt.next_pc = ((s1_addr_a_r == LINK_REG) ? s1_pc_r : opa[15:0]) & PC_MASK;
      end
      OP_HLT: begin
        s2_nxt.halt    = 1'b1;
        s2_nxt.next_pc = s1_pc_r & PC_MASK;
      end
      default: begin
        s2_nxt.halt    = 1'b1;
        s2_nxt.next_pc = s1_pc_r & PC_MASK;
      end
    endcase
    if (jcond) begin
      s2_nxt.taken   = 1'b1;
      s2_nxt.wr      = 1'b1;
      s2_nxt.widx    = LINK_REG;
      s2_nxt.wval    = {16'd0, s1_pc_r};
      s2_nxt.next_pc = s1_imm_r & PC_MASK;
    end
    // r0 is hard-wired to zero
    if (s2_nxt.widx == 3'd0) begin
      s2_nxt.wr = 1'b0;
    end
    if (!s2_nxt.wr) begin
      s2_nxt.widx = '0;
      s2_nxt.wval = '0;
    end
  end

  assign dm_we = s1_valid_r && (s1_op_r == OP_ST) && b_in_range;

  rxs_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (opb[DM_AW-1:0]),
    .wdata (opa),
    .raddr (opb[DM_AW-1:0]),
    .rdata (dm_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      wb_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
      wb_valid_r <= rf_we;
    end
  end

  always_ff @(posedge clk) begin
    s2_r     <= s2_nxt;
    wb_idx_r <= rf_waddr;
    wb_val_r <= rf_wdata;
  end

  always_comb begin
    if (!s2_r.wr) begin
      s2_wval = '0;
    end else if (s2_r.is_ld) begin
      s2_wval = s2_r.ld_oob ? '0 : dm_rdata;
    end else begin
      s2_wval = s2_r.wval;
    end
  end

  assign rf_we    = s2_valid_r && s2_r.wr;
  assign rf_waddr = s2_r.widx;
  assign rf_wdata = s2_wval;

  always_comb begin
    q_push_data.next_pc     = s2_r.next_pc;
    q_push_data.jump_taken  = s2_r.taken;
    q_push_data.halted      = s2_r.halt;
    q_push_data.reg_write   = s2_r.wr;
    q_push_data.write_index = s2_r.widx;
    q_push_data.write_value = s2_wval;
  end

  rxs_out_fifo #(.DEPTH(OUT_Q_DEPTH)) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_valid_r),
    .push_data (q_push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (q_count)
  );

  // queue slots are reserved for every item still in the pipe
  assign occ      = OCC_W'(q_count) + OCC_W'(s1_valid_r) + OCC_W'(s2_valid_r);
  assign in_ready = (occ < OCC_W'(OUT_Q_DEPTH));

  a_r0_never_written: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> rf_waddr != '0)
    else $error("register zero written");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= OCC_W'(OUT_Q_DEPTH))
    else $error("result queue over-committed");

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##2 s2_valid_r)
    else $error("accepted item did not reach write-back");

  a_halt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.halted |-> !out_data.reg_write && !out_data.jump_taken)
    else $error("halt item carries a write or a jump");

endmodule

`default_nettype wire

### tb/risc_execute_stage_tb.sv
module risc_execute_stage_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rxs_pkg::*;

  localparam int MEM_WORDS   = MEM_DEPTH_DEF;
  localparam int ADDR_W      = $clog2(MEM_WORDS);
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  rxs_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rxs_out_t out_data;

  // architectural state as the instruction stream leaves it
  logic [31:0] arch_regs [NUM_REGS] = '{default: '0};
  logic [31:0] data_words [MEM_WORDS];
  bit          word_written [MEM_WORDS] = '{default: 1'b0};

  rxs_out_t    retire_q [$];
  rxs_out_t    want_r;
  int unsigned errs      = 0;
  int unsigned n_items   = 0;
  int unsigned cycle_cnt = 0;
  bit          idle_on   = 1'b0;
  bit          hold_req  = 1'b0;

  risc_execute_stage dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic rxs_out_t execute_instr(rxs_in_t it);
    logic [31:0] a, b, imm, val;
    logic [15:0] nxt;
    logic        tk, hl, wr, cond;
    logic [2:0]  widx;
    rxs_out_t    r;
    a    = arch_regs[it.src0_reg];
    b    = arch_regs[it.src1_reg];
    imm  = {{16{it.immediate[15]}}, it.immediate};
    nxt  = it.current_pc + 16'd1;
    tk   = 1'b0;
    hl   = 1'b0;
    wr   = 1'b0;
    cond = 1'b0;
    widx = '0;
    val  = '0;
    case (rxs_op_t'(it.req_type))
      OP_ADD: begin wr = 1'b1; widx = it.dest_reg; val = a + b; end
      OP_SUB: begin wr = 1'b1; widx = it.dest_reg; val = a - b; end
      OP_LSF: begin wr = 1'b1; widx = it.dest_reg; val = a << b[4:0]; end
      OP_RSF: begin wr = 1'b1; widx = it.dest_reg; val = $unsigned($signed(a) >>> b[4:0]); end
      OP_AND: begin wr = 1'b1; widx = it.dest_reg; val = a & b; end
      OP_OR:  begin wr = 1'b1; widx = it.dest_reg; val = a | b; end
      OP_XOR: begin wr = 1'b1; widx = it.dest_reg; val = a ^ b; end
      OP_LHI: begin
        wr = 1'b1;
        widx = it.dest_reg;
        val = {it.immediate, arch_regs[it.dest_reg][15:0]};
      end
      OP_LD: begin
        wr = 1'b1;
        widx = it.dest_reg;
        val = (b < MEM_WORDS) ? data_words[b[ADDR_W-1:0]] : 32'd0;
      end
      OP_ST: begin
        if (b < MEM_WORDS) begin
          data_words[b[ADDR_W-1:0]] = a;
          word_written[b[ADDR_W-1:0]] = 1'b1;
        end
      end
      OP_JLT: cond = $signed(a) < $signed(b);
      OP_JLE: cond = $signed(a) <= $signed(b);
      OP_JEQ: cond = a == b;
      OP_JNE: cond = a != b;
      OP_JIN: begin
        // link is written before the target is read
        tk = 1'b1;
        arch_regs[LINK_REG] = {16'd0, it.current_pc};
        nxt = arch_regs[it.src0_reg][15:0];
        wr = 1'b1;
        widx = LINK_REG;
        val = {16'd0, it.current_pc};
      end
      default: begin
        hl = 1'b1;
        nxt = it.current_pc;
      end
    endcase
    if (cond) begin
      tk = 1'b1;
      nxt = imm[15:0];
      wr = 1'b1;
      widx = LINK_REG;
      val = {16'd0, it.current_pc};
    end
    if (wr && widx == 3'd0) wr = 1'b0;
    if (wr) begin
      arch_regs[widx] = val;
    end else begin
      widx = '0;
      val = '0;
    end
    r.next_pc     = nxt;
    r.jump_taken  = tk;
    r.halted      = hl;
    r.reg_write   = wr;
    r.write_index = widx;
    r.write_value = val;
    return r;
  endfunction

  function automatic logic [2:0] rnd_reg();
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  // a load must never touch a word that was not stored since reset
  function automatic bit load_ok(logic [2:0] r);
    logic [31:0] adr;
    adr = arch_regs[r];
    return (adr >= MEM_WORDS) || word_written[adr[ADDR_W-1:0]];
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 32'($urandom_range(0, 15));
      6: return 32'($urandom_range(MEM_WORDS - 16, MEM_WORDS - 1));
      7: return 32'($urandom_range(MEM_WORDS, MEM_WORDS + 16));
      8: return {1'b1, 31'($urandom)};
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return 32'hffff_ffff;
      default: return 32'($urandom);
    endcase
  endfunction

  task automatic issue(rxs_op_t op, logic [2:0] d, logic [2:0] s0, logic [2:0] s1,
                       logic [15:0] imm, logic [15:0] pc);
    rxs_in_t it;
    it.req_type   = op;
    it.dest_reg   = d;
    it.src0_reg   = s0;
    it.src1_reg   = s1;
    it.immediate  = imm;
    it.current_pc = pc;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    retire_q.push_back(execute_instr(it));
    n_items++;
  endtask

  // r7 picks up the low half through the link of a jin, lhi fills the top
  task automatic load_const(logic [2:0] rd, logic [31:0] v);
    issue(OP_JIN, rnd_reg(), rnd_reg(), rnd_reg(), rnd16(), v[15:0]);
    issue(OP_LHI, LINK_REG, rnd_reg(), rnd_reg(), v[31:16], rnd16());
    if (rd != LINK_REG) issue(OP_ADD, rd, LINK_REG, 3'd0, rnd16(), rnd16());
  endtask

  task automatic send_random_instr();
    rxs_op_t    op;
    logic [2:0] s1;
    op = rxs_op_t'(4'($urandom_range(0, 15)));
    s1 = rnd_reg();
    if (op == OP_LD && !load_ok(s1)) begin
      if (load_ok(3'd0)) s1 = 3'd0;
      else op = OP_ST;
    end
    issue(op, rnd_reg(), rnd_reg(), s1, rnd16(), rnd16());
  endtask

  task automatic mem_sequence();
    logic [2:0] ra, rd, rl;
    ra = 3'($urandom_range(1, 6));
    rd = 3'($urandom_range(1, 6));
    if (rd == ra) rd = (ra == 3'd6) ? 3'd1 : ra + 3'd1;
    rl = rnd_reg();
    load_const(ra, pick_addr());
    if ($urandom_range(0, 3) != 0) load_const(rd, pick_value());
    issue(OP_ST, rnd_reg(), ($urandom_range(0, 7) == 0) ? 3'd0 : rd, ra, rnd16(), rnd16());
    repeat ($urandom_range(0, 2)) send_random_instr();
    if (load_ok(ra)) begin
      issue(OP_LD, rl, rnd_reg(), ra, rnd16(), rnd16());
      // consumer straight after the load
      issue(rxs_op_t'(4'($urandom_range(0, 6))), rnd_reg(), rl, rnd_reg(), rnd16(), rnd16());
    end
  endtask

  task automatic branch_sequence();
    logic [2:0]  ra, rb;
    logic [31:0] va, vb;
    rxs_op_t     op;
    ra = 3'($urandom_range(1, 6));
    rb = 3'($urandom_range(1, 6));
    if (rb == ra) rb = (ra == 3'd6) ? 3'd1 : ra + 3'd1;
    va = pick_value();
    case ($urandom_range(0, 4))
      0: vb = va;
      1: vb = va + 32'd1;
      2: vb = va - 32'd1;
      3: vb = ~va;
      default: vb = pick_value();
    endcase
    load_const(ra, va);
    load_const(rb, vb);
    op = rxs_op_t'(4'($urandom_range(OP_JLT, OP_JNE)));
    case ($urandom_range(0, 4))
      0: issue(op, rnd_reg(), ra, ra, rnd16(), rnd16());
      1, 2: issue(op, rnd_reg(), ra, rb, rnd16(), rnd16());
      default: issue(op, rnd_reg(), rb, ra, rnd16(), rnd16());
    endcase
    if ($urandom_range(0, 3) == 0) issue(OP_JIN, rnd_reg(), rnd_reg(), rnd_reg(), rnd16(), rnd16());
  endtask

  // dependent alu chain on one register
  task automatic alu_sequence();
    logic [2:0] ra, rb;
    ra = 3'($urandom_range(1, 6));
    rb = 3'($urandom_range(1, 6));
    if (rb == ra) rb = (ra == 3'd6) ? 3'd1 : ra + 3'd1;
    load_const(ra, pick_value());
    load_const(rb, ($urandom_range(0, 1) == 1) ? 32'($urandom_range(0, 63)) : pick_value());
    repeat ($urandom_range(1, 4))
      issue(rxs_op_t'(4'($urandom_range(0, 6))), ra, ra, rb, rnd16(), rnd16());
  endtask

  task automatic test_directed_ops();
    idle_on = 1'b0;
    load_const(3'd1, 32'h8000_0001);
    load_const(3'd2, 32'h0000_0021);
    issue(OP_ADD, 3'd3, 3'd1, 3'd1, 16'h0000, 16'h0010);
    issue(OP_SUB, 3'd4, 3'd0, 3'd1, 16'h0000, 16'h0011);
    issue(OP_LSF, 3'd5, 3'd1, 3'd2, 16'h0000, 16'h0012);
    issue(OP_RSF, 3'd6, 3'd1, 3'd2, 16'h0000, 16'h0013);
    issue(OP_AND, 3'd3, 3'd1, 3'd6, 16'hffff, 16'h0014);
    issue(OP_OR,  3'd4, 3'd1, 3'd2, 16'h8000, 16'h0015);
    issue(OP_XOR, 3'd5, 3'd1, 3'd6, 16'h7fff, 16'h0016);
    // writes to r0 go nowhere
    issue(OP_LHI, 3'd0, 3'd1, 3'd2, 16'h7fff, 16'h0017);
    issue(OP_ADD, 3'd0, 3'd1, 3'd2, 16'h0000, 16'h0018);
    issue(OP_ST,  3'd0, 3'd1, 3'd2, 16'h0000, 16'h0019);
    issue(OP_LD,  3'd3, 3'd0, 3'd2, 16'h0000, 16'h001a);
    issue(OP_ADD, 3'd4, 3'd3, 3'd3, 16'h0000, 16'h001b);
    // address beyond the memory: store dropped, load gives zero
    issue(OP_ST,  3'd0, 3'd2, 3'd1, 16'h0000, 16'h001c);
    issue(OP_LD,  3'd4, 3'd0, 3'd1, 16'h0000, 16'h001d);
    issue(OP_JLT, 3'd0, 3'd1, 3'd2, 16'hffff, 16'h001e);
    issue(OP_JLE, 3'd0, 3'd2, 3'd1, 16'h0040, 16'h001f);
    issue(OP_JEQ, 3'd0, 3'd3, 3'd3, 16'h8000, 16'h0020);
    issue(OP_JNE, 3'd0, 3'd0, 3'd0, 16'h1234, 16'hffff);
    issue(OP_JIN, 3'd5, 3'd7, 3'd4, 16'h0000, 16'habcd);
    issue(OP_JIN, 3'd6, 3'd1, 3'd5, 16'h0000, 16'h0000);
    issue(OP_HLT, 3'd7, 3'd7, 3'd7, 16'hffff, 16'h1234);
  endtask

  task automatic test_memory();
    int unsigned start;
    start = n_items;
    idle_on = 1'b1;
    while (n_items - start < 200) begin
      if ($urandom_range(0, 4) != 0) mem_sequence();
      else send_random_instr();
    end
  endtask

  task automatic test_branches();
    int unsigned start;
    start = n_items;
    idle_on = 1'b1;
    while (n_items - start < 150) begin
      if ($urandom_range(0, 4) != 0) branch_sequence();
      else send_random_instr();
    end
  endtask

  task automatic test_backpressure();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_random_instr();
  endtask

  task automatic test_random_mix();
    while (n_items < 780) begin
      idle_on = (n_items < 660) && ((n_items / 60) % 3 != 2);
      case ($urandom_range(0, 5))
        0, 1: mem_sequence();
        2, 3: branch_sequence();
        4: alu_sequence();
        default: repeat ($urandom_range(1, 6)) send_random_instr();
      endcase
    end
  endtask

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (retire_q.size() == 0) begin
        $error("result item with nothing pending: %p", out_data);
        errs++;
      end else begin
        want_r = retire_q.pop_front();
        check_field("next_pc", 32'(want_r.next_pc), 32'(out_data.next_pc));
        check_field("jump_taken", 32'(want_r.jump_taken), 32'(out_data.jump_taken));
        check_field("halted", 32'(want_r.halted), 32'(out_data.halted));
        check_field("reg_write", 32'(want_r.reg_write), 32'(out_data.reg_write));
        check_field("write_index", 32'(want_r.write_index), 32'(out_data.write_index));
        check_field("write_value", want_r.write_value, out_data.write_value);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_memory();
    test_branches();
    test_backpressure();
    test_random_mix();
    in_valid <= 1'b0;
    while (retire_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errs == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
